/* hw/rtl/path_string_tokenizer_core_macros.svh */
// ----------------------------------------------------------------------------
// Path tokenizer assertion macros
// Shared concurrent-assertion shorthands, sampled on the rising clock edge and
// held off while reset is active.
// ----------------------------------------------------------------------------
`ifndef PATH_STRING_TOKENIZER_CORE_MACROS_SVH
`define PATH_STRING_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication
`define PST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("path tokenizer: same-cycle check failed");

// next-cycle implication
`define PST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("path tokenizer: next-cycle check failed");

`endif

/* hw/rtl/pst_pkg.sv */
// ----------------------------------------------------------------------------
// Path tokenizer package
// Result record, queue entry, role codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam logic [1:0] ROLE_COMP = 2'd0;
  localparam logic [1:0] ROLE_SEP  = 2'd1;
  localparam logic [1:0] ROLE_DROP = 2'd2;

  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_Z    = 8'h7A;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_Z     = 8'h5A;
  localparam logic [7:0] CH_DIG_0    = 8'h30;
  localparam logic [7:0] CH_DIG_9    = 8'h39;
  localparam logic [7:0] DRIVE_RESET = 8'h43;
  localparam logic [7:0] DEPTH_MAX   = 8'hFF;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] role;
    logic [7:0] idx;
    logic       is_last;
    logic       valid;
    logic       absolute;
    logic       directory;
    logic [7:0] depth;
  } res_t;

  // one accepted byte: one or two results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/pst_if.sv */
// ----------------------------------------------------------------------------
// Path tokenizer channels
// Valid/ready channels for path bytes in and tagged results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       last_char;

  modport source (output valid, output in_char, output last_char, input ready);
  modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface pst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] char_role;
  logic [7:0] component_index;
  logic       is_last;
  logic       path_valid;
  logic       path_absolute;
  logic       path_directory;
  logic [7:0] path_depth;

  modport source (output valid, output out_char, output char_role, output component_index,
                  output is_last, output path_valid, output path_absolute,
                  output path_directory, output path_depth, input ready);
  modport sink   (input valid, input out_char, input char_role, input component_index,
                  input is_last, input path_valid, input path_absolute,
                  input path_directory, input path_depth, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pst_queue.sv */
// ----------------------------------------------------------------------------
// Path tokenizer queue
// Small register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_queue
  import pst_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pst_front.sv */
// ----------------------------------------------------------------------------
// Path tokenizer front
// Accepts bytes, runs the path parse state and builds result records.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_front
  import pst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       last_char,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_HELD   = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  typedef struct packed {
    logic       nonempty;
    logic [7:0] depth;
    logic       ok;
  } pstate_t;

  typedef struct packed {
    pstate_t s;
    res_t    r;
  } step_t;

  localparam pstate_t PSTATE_RESET = '{nonempty: 1'b0, depth: 8'd0, ok: 1'b1};

  function automatic logic char_allowed(input logic [7:0] c);
    return c inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z], [CH_DIG_0:CH_DIG_9],
                     CH_SLASH, CH_DOT, CH_UNDER};
  endfunction

  function automatic res_t mk_res(input logic [7:0] c, input logic [1:0] role,
                                  input logic [7:0] idx);
    res_t r;
    r      = '0;
    r.ch   = c;
    r.role = role;
    r.idx  = idx;
    return r;
  endfunction

  function automatic step_t body_step(input pstate_t s, input logic [7:0] c);
    step_t o;
    o.s = s;
    if (c == CH_SLASH) begin
      if (!s.nonempty) o.s.ok = 1'b0;
      o.r = mk_res(c, ROLE_SEP, s.depth);
      if (s.depth != DEPTH_MAX) o.s.depth = s.depth + 8'd1;
      o.s.nonempty = 1'b0;
    end else begin
      if (!char_allowed(c)) o.s.ok = 1'b0;
      o.r = mk_res(c, ROLE_COMP, s.depth);
      o.s.nonempty = 1'b1;
    end
    return o;
  endfunction

  // leading slash of a relative path is dropped but flags the path
  function automatic step_t first_step(input pstate_t s, input logic [7:0] c);
    step_t o;
    if (c == CH_SLASH) begin
      o.s    = s;
      o.s.ok = 1'b0;
      o.r    = mk_res(c, ROLE_DROP, 8'd0);
    end else begin
      o = body_step(s, c);
    end
    return o;
  endfunction

  logic [7:0] drive_r;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  pstate_t    st_r, st_nxt;
  logic       abs_r, abs_nxt;

  logic       accept;
  logic       push;
  entry_t     ent;
  step_t      sa, sb;
  logic [7:0] fin_depth;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && push;
  assign q_entry  = ent;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    st_nxt    = st_r;
    abs_nxt   = abs_r;
    push      = 1'b0;
    ent       = '0;
    sa        = '0;
    sb        = '0;
    fin_depth = '0;

    case (phase_r)
      PH_START: begin
        if (!last_char && in_char == drive_r) begin
          held_nxt  = in_char;
          phase_nxt = PH_HELD;
        end else begin
          sa        = first_step(st_r, in_char);
          st_nxt    = sa.s;
          ent.r0    = sa.r;
          push      = 1'b1;
          phase_nxt = PH_BODY;
        end
      end
      PH_HELD: begin
        push    = 1'b1;
        ent.two = 1'b1;
        if (in_char == CH_COLON) begin
          abs_nxt   = 1'b1;
          ent.r0    = mk_res(held_r, ROLE_DROP, 8'd0);
          ent.r1    = mk_res(in_char, ROLE_DROP, 8'd0);
          phase_nxt = PH_PREFIX;
        end else begin
          sa        = first_step(st_r, held_r);
          sb        = body_step(sa.s, in_char);
          st_nxt    = sb.s;
          ent.r0    = sa.r;
          ent.r1    = sb.r;
          phase_nxt = PH_BODY;
        end
      end
      PH_PREFIX: begin
        push      = 1'b1;
        phase_nxt = PH_BODY;
        if (in_char == CH_SLASH) begin
          ent.r0 = mk_res(in_char, ROLE_DROP, 8'd0);
        end else begin
          sa.s      = st_r;
          sa.s.ok   = 1'b0;
          sb        = body_step(sa.s, in_char);
          st_nxt    = sb.s;
          ent.r0    = sb.r;
        end
      end
      default: begin
        push      = 1'b1;
        sa        = body_step(st_r, in_char);
        st_nxt    = sa.s;
        ent.r0    = sa.r;
        phase_nxt = PH_BODY;
      end
    endcase

    // summary rides on the final result; path state starts over
    if (last_char) begin
      fin_depth = st_nxt.depth;
      if (st_nxt.nonempty && st_nxt.depth != DEPTH_MAX) fin_depth = st_nxt.depth + 8'd1;
      if (ent.two) begin
        ent.r1.is_last   = 1'b1;
        ent.r1.valid     = st_nxt.ok;
        ent.r1.absolute  = abs_nxt;
        ent.r1.directory = (in_char == CH_SLASH);
        ent.r1.depth     = fin_depth;
      end else begin
        ent.r0.is_last   = 1'b1;
        ent.r0.valid     = st_nxt.ok;
        ent.r0.absolute  = abs_nxt;
        ent.r0.directory = (in_char == CH_SLASH);
        ent.r0.depth     = fin_depth;
      end
      phase_nxt = PH_START;
      held_nxt  = '0;
      st_nxt    = PSTATE_RESET;
      abs_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= DRIVE_RESET;
      phase_r <= PH_START;
      held_r  <= '0;
      st_r    <= PSTATE_RESET;
      abs_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        drive_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        st_r    <= st_nxt;
        abs_r   <= abs_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pst_back.sv */
// ----------------------------------------------------------------------------
// Path tokenizer back
// Unpacks queued entries into single results behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_back
  import pst_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  entry_t q_head,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  logic out_valid_r, out_valid_nxt;
  logic sel_r, sel_nxt;
  res_t res_r;
  logic load;

  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    sel_nxt       = sel_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      // second result of a two-result entry is loaded when the first one is taken
      if (q_head.two && !sel_r) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        q_pop   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= sel_r ? q_head.r1 : q_head.r0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/path_string_tokenizer_core.sv */
// Flow: an accepted byte's result is written to the queue and then loaded into the
//   output register; a held drive letter waits for the next byte.
// Throughput: one byte per cycle while the queue has room; the byte after a held
//   drive letter yields two results, which leave the output register one per cycle while the receiver is ready.
// The front parser takes a byte each cycle the queue of QUEUE_DEPTH entries has room.
// Reset (synchronous, rst_n low) empties the queue, clears the path state and
//   sets the drive letter to 'C'.
// ----------------------------------------------------------------------------
// Path string tokenizer
// Tags path bytes as component, separator or dropped (prefix or leading slash) and
// reports a per-path summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module path_string_tokenizer_core
  import pst_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  pst_in_if.sink     in_if,
  pst_out_if.source  out_if
);

  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_wdata, q_head;
  res_t   res;

  pst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_char   (in_if.in_char),
    .last_char (in_if.last_char),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  pst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  pst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  assign out_if.out_char        = res.ch;
  assign out_if.char_role       = res.role;
  assign out_if.component_index = res.idx;
  assign out_if.is_last         = res.is_last;
  assign out_if.path_valid      = res.valid;
  assign out_if.path_absolute   = res.absolute;
  assign out_if.path_directory  = res.directory;
  assign out_if.path_depth      = res.depth;

endmodule

`default_nettype wire

/* hw/rtl/pst_checker.sv */
// ----------------------------------------------------------------------------
// Path tokenizer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "path_string_tokenizer_core_macros.svh"

module pst_checker
  import pst_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic [1:0] char_role,
  input wire logic [7:0] component_index,
  input wire logic       is_last,
  input wire logic       path_valid,
  input wire logic       path_absolute,
  input wire logic       path_directory,
  input wire logic [7:0] path_depth
);

  // stalled beat holds its payload
  `PST_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(char_role) && $stable(component_index) && $stable(is_last))

  `PST_ASSERT_IMPLY(a_role_code, clk, rst_n, out_valid, char_role == ROLE_COMP || char_role == ROLE_SEP || char_role == ROLE_DROP)

  // summary fields only on the closing beat of a path
  `PST_ASSERT_IMPLY(a_summary_zero, clk, rst_n, out_valid && !is_last, !path_valid && !path_absolute && !path_directory && path_depth == 8'd0)

  `PST_ASSERT_IMPLY(a_drop_index, clk, rst_n, out_valid && char_role == ROLE_DROP, component_index == 8'd0)

endmodule

bind path_string_tokenizer_core pst_checker u_pst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_char        (out_if.out_char),
  .char_role       (out_if.char_role),
  .component_index (out_if.component_index),
  .is_last         (out_if.is_last),
  .path_valid      (out_if.path_valid),
  .path_absolute   (out_if.path_absolute),
  .path_directory  (out_if.path_directory),
  .path_depth      (out_if.path_depth)
);

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Path string tokenizer testbench
// Streams path bytes into path_string_tokenizer_core and checks every result
// beat against an in-bench tokenizer with its own path state and drive letter.
// Directed paths cover the prefix, root, held-letter and error cases; random
// paths are mostly well-formed with some noise. Both channels idle at random,
// and the drive letter is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int unsigned ITEM_TARGET = 1200;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned HOLD_LONG   = 80;
  localparam int unsigned REPORT_MAX  = 60;

  typedef enum logic [1:0] {
    PARSE_START,
    PARSE_HELD,
    PARSE_PREFIX,
    PARSE_BODY
  } parse_e;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  pst_in_if  in_bus();
  pst_out_if out_bus();

  path_string_tokenizer_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_bus),
    .out_if   (out_bus)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // tokenizer state
  parse_e     parse_st;
  logic [7:0] held_byte;
  logic       comp_open;
  logic [7:0] depth_cnt;
  logic       path_ok;
  logic       path_abs;
  logic [7:0] drive_letter_m;

  res_t        pending_results[$];
  int          errors;
  int unsigned bytes_sent;
  logic        in_gaps_on;
  logic        out_stalls_on;
  int unsigned hold_cycles;

  function automatic res_t mk_res(input logic [7:0] c, input logic [1:0] role,
                                  input logic [7:0] idx);
    res_t r;
    r      = '0;
    r.ch   = c;
    r.role = role;
    r.idx  = idx;
    return r;
  endfunction

  function automatic logic char_legal(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9) || c == CH_SLASH || c == CH_DOT ||
           c == CH_UNDER;
  endfunction

  function automatic void clear_path();
    parse_st  = PARSE_START;
    held_byte = '0;
    comp_open = 1'b0;
    depth_cnt = '0;
    path_ok   = 1'b1;
    path_abs  = 1'b0;
  endfunction

  function automatic res_t body_byte(input logic [7:0] c);
    res_t r;
    if (c == CH_SLASH) begin
      if (!comp_open) path_ok = 1'b0;
      r = mk_res(c, ROLE_SEP, depth_cnt);
      if (depth_cnt != DEPTH_MAX) depth_cnt++;
      comp_open = 1'b0;
    end else begin
      if (!char_legal(c)) path_ok = 1'b0;
      r = mk_res(c, ROLE_COMP, depth_cnt);
      comp_open = 1'b1;
    end
    parse_st = PARSE_BODY;
    return r;
  endfunction

  // first byte of a relative path: a slash here is an illegal root, dropped
  function automatic res_t lead_byte(input logic [7:0] c);
    if (c == CH_SLASH) begin
      path_ok  = 1'b0;
      parse_st = PARSE_BODY;
      return mk_res(c, ROLE_DROP, '0);
    end
    return body_byte(c);
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic is_end);
    res_t        r0;
    res_t        r1;
    res_t        tail;
    logic        two;
    logic [7:0]  d;
    r1  = '0;
    two = 1'b0;
    case (parse_st)
      PARSE_START: begin
        if (!is_end && c == drive_letter_m) begin
          held_byte = c;
          parse_st  = PARSE_HELD;
          return;
        end
        r0 = lead_byte(c);
      end
      PARSE_HELD: begin
        two = 1'b1;
        if (c == CH_COLON) begin
          path_abs = 1'b1;
          r0       = mk_res(held_byte, ROLE_DROP, '0);
          r1       = mk_res(c, ROLE_DROP, '0);
          parse_st = PARSE_PREFIX;
        end else begin
          r0 = lead_byte(held_byte);
          r1 = body_byte(c);
        end
      end
      PARSE_PREFIX: begin
        if (c == CH_SLASH) begin
          r0       = mk_res(c, ROLE_DROP, '0);
          parse_st = PARSE_BODY;
        end else begin
          path_ok = 1'b0;
          r0      = body_byte(c);
        end
      end
      default: r0 = body_byte(c);
    endcase
    if (is_end) begin
      d = depth_cnt;
      if (comp_open && d != DEPTH_MAX) d++;
      tail           = two ? r1 : r0;
      tail.is_last   = 1'b1;
      tail.valid     = path_ok;
      tail.absolute  = path_abs;
      tail.directory = (c == CH_SLASH);
      tail.depth     = d;
      if (two) r1 = tail;
      else r0 = tail;
      clear_path();
    end
    pending_results = {pending_results, r0};
    if (two) pending_results = {pending_results, r1};
  endfunction

  function automatic void check_field(input string field, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endfunction

  // result check first, then prediction for the byte taken at this edge
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected result beat, char %0d role %0d", $time,
                     out_bus.out_char, out_bus.char_role);
        end else begin
          want = pending_results.pop_front();
          check_field("out_char", want.ch, out_bus.out_char);
          check_field("char_role", 8'(want.role), 8'(out_bus.char_role));
          check_field("component_index", want.idx, out_bus.component_index);
          check_field("is_last", 8'(want.is_last), 8'(out_bus.is_last));
          check_field("path_valid", 8'(want.valid), 8'(out_bus.path_valid));
          check_field("path_absolute", 8'(want.absolute), 8'(out_bus.path_absolute));
          check_field("path_directory", 8'(want.directory), 8'(out_bus.path_directory));
          check_field("path_depth", want.depth, out_bus.path_depth);
        end
      end
      if (in_bus.valid && in_bus.ready) tokenize_byte(in_bus.in_char, in_bus.last_char);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned n;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = out_stalls_on ? pick_gap() : 0;
        if (n != 0) begin
          out_bus.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic is_end);
    int unsigned gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.in_char   <= c;
    in_bus.last_char <= is_end;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
  endtask

  task automatic send_path(input byte_q_t p);
    foreach (p[k]) send_byte(p[k], k == p.size() - 1);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
  endtask

  // idle the input first so the prediction for the last accepted byte is queued
  task automatic wait_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_drive_letter(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we         <= 1'b0;
    drive_letter_m  = v;
  endtask

  function automatic logic [7:0] legal_byte();
    case ($urandom_range(0, 4))
      0: return CH_UP_A + 8'($urandom_range(0, 25));
      1: return CH_DIG_0 + 8'($urandom_range(0, 9));
      2: return $urandom_range(0, 1) ? CH_DOT : CH_UNDER;
      default: return CH_LOW_A + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic void append_byte(ref byte_q_t q, input logic [7:0] c);
    q = {q, c};
  endfunction

  // mostly well-formed paths with random content; some corrupted, some noise
  task automatic send_random_path();
    byte_q_t     p;
    int unsigned kind;
    int unsigned ncomp;
    int unsigned len;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      len = $urandom_range(1, 8);
      repeat (len) append_byte(p, 8'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        append_byte(p, drive_letter_m);
        append_byte(p, CH_COLON);
        if ($urandom_range(0, 5) != 0) append_byte(p, CH_SLASH);
      end else if ($urandom_range(0, 7) == 0) begin
        append_byte(p, drive_letter_m);
      end
      ncomp = $urandom_range(0, 4);
      for (int k = 0; k < ncomp; k++) begin
        if (k != 0) append_byte(p, CH_SLASH);
        len = $urandom_range(1, 5);
        repeat (len) append_byte(p, legal_byte());
      end
      if ($urandom_range(0, 3) == 0) append_byte(p, CH_SLASH);
      if (p.size() == 0) append_byte(p, legal_byte());
      if (kind < 5) p[$urandom_range(0, p.size() - 1)] = 8'($urandom);
      else if (kind == 5) p.insert($urandom_range(0, p.size()), CH_SLASH);
    end
    send_path(p);
  endtask

  task automatic test_directed();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_text("C:/a");          // prefix and root
    send_text("C:");            // prefix alone
    send_text("Cx");            // held letter without colon
    send_text("/");             // relative root slash, directory
    send_text("a//");           // empty component
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("C:z");           // prefix not followed by slash
    send_text("C");             // lone drive letter
    send_text("_.9");
    send_text("C::");           // colon after prefix
    wait_results();
  endtask

  task automatic test_depth_saturation();
    byte_q_t p;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    repeat (260) begin
      append_byte(p, CH_LOW_A);
      append_byte(p, CH_SLASH);
    end
    append_byte(p, CH_UP_Z);
    send_path(p);
    wait_results();
  endtask

  task automatic test_drive_letter();
    logic [7:0] letters[7];
    letters = '{8'h00, 8'hFF, CH_COLON, CH_SLASH, CH_LOW_A, 8'($urandom), DRIVE_RESET};
    foreach (letters[k]) begin
      write_drive_letter(letters[k]);
      in_gaps_on    = $urandom_range(0, 1);
      out_stalls_on = $urandom_range(0, 1);
      send_path('{letters[k], CH_COLON, CH_SLASH, CH_LOW_Z});
      send_path('{letters[k]});
      send_path('{letters[k], letters[k]});
      repeat (3) send_random_path();
      wait_results();
    end
  endtask

  task automatic test_backpressure();
    int unsigned goal;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    hold_cycles   = HOLD_LONG;
    goal          = bytes_sent + 40;
    while (bytes_sent < goal) send_random_path();
    wait_results();
    // resume after a full drain
    repeat (5) send_random_path();
    wait_results();
  endtask

  task automatic test_random();
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) write_drive_letter(DRIVE_RESET);
      else write_drive_letter(8'($urandom));
      repeat (10) begin
        if ($urandom_range(0, 7) == 0) in_gaps_on = ~in_gaps_on;
        if ($urandom_range(0, 7) == 0) out_stalls_on = ~out_stalls_on;
        send_random_path();
      end
      wait_results();
    end
  endtask

  initial begin
    errors        = 0;
    bytes_sent    = 0;
    hold_cycles   = 0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    drive_letter_m = DRIVE_RESET;
    clear_path();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.in_char   <= '0;
    in_bus.last_char <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_depth_saturation();
    test_drive_letter();
    test_backpressure();
    test_random();

    in_bus.valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (errors == 0) $display("PASS path_string_tokenizer_core");
    else $display("FAIL path_string_tokenizer_core");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL path_string_tokenizer_core");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/pst_pkg.sv
hw/rtl/pst_if.sv
hw/rtl/pst_queue.sv
hw/rtl/pst_front.sv
hw/rtl/pst_back.sv
hw/rtl/path_string_tokenizer_core.sv
hw/rtl/pst_checker.sv
dv/tb.sv
